>>> sv/rsmm_pkg.sv
// package: types and constants for the range sum min max tree core
package rsmm_pkg;
    localparam int LEAVES = 1024;
    localparam int IDX_W = $clog2(LEAVES);
    localparam int CNT_W = 11;
    localparam int SUM_W = 42;
    localparam int VAL_W = 32;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_QRY = 2'd2;
    localparam logic [1:0] CMD_RSV = 2'd3;

    localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] INT_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [IDX_W-1:0]        range_start;
        logic [IDX_W-1:0]        range_end;
        logic signed [VAL_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] range_sum;
        logic signed [VAL_W-1:0] range_max;
        logic signed [VAL_W-1:0] range_min;
        logic                    range_empty;
    } out_word_t;
endpackage

>>> sv/rsmm_ram.sv
// generic single port synchronous ram, read data registered from the address of the cycle before
module rsmm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> sv/range_sum_min_max_tree_core.sv
// top level: leaf memory with read-modify-write sequencer and range scan
//
//  channel | ports           | dir | word
//  --------+-----------------+-----+-----------------------------
//  input   | s_valid/s_ready | in  | in_word_t: cmd, range, value
//  result  | m_valid/m_ready | out | out_word_t: sum, max, min, empty
//  config  | cfg_valid/ready | in  | element_count (11 bits)
//
// after reset a clearing pass zeroes every leaf of the memory; no item is
// accepted during it. an update walks its range leaf by leaf (read, then write
// back), then scans all leaves in use, one read per cycle; a query scans only
// its clipped range. the leaf memory has a single port, so an update reads and
// writes each leaf in turn. the result sits in an output register; the next
// item is taken while it waits, and its finish stalls on it.
module range_sum_min_max_tree_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rsmm_pkg::in_word_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output rsmm_pkg::out_word_t          m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rsmm_pkg::CNT_W-1:0]   cfg_data
);
    import rsmm_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_URD   = 3'd2;
    localparam logic [2:0] ST_UWR   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             empty_reg, empty_next;
    logic             rd_pend_reg, rd_pend_next; // scan read data arrives this cycle
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [VAL_W-1:0] max_reg, max_next, min_reg, min_next;
    logic             mv_reg;
    out_word_t        mdat_reg;

    logic             we;
    logic [IDX_W-1:0] ram_addr;
    logic [VAL_W-1:0] wdata, rdata;

    rsmm_ram #(.DEPTH(LEAVES), .WIDTH(VAL_W)) u_leaves (
        .aclk(aclk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
    );

    // clip count to the leaves present
    logic [CNT_W-1:0] cnt_use;
    logic [CNT_W-1:0] lo_x, hi_x;
    logic             in_empty, upd;
    logic [IDX_W-1:0] hi_clip, last_idx;
    always_comb begin
        cnt_use  = (count_reg > CNT_W'(LEAVES)) ? CNT_W'(LEAVES) : count_reg;
        lo_x     = CNT_W'(s_data.range_start);
        hi_x     = CNT_W'(s_data.range_end);
        in_empty = (cnt_use == '0) || (s_data.range_start > s_data.range_end)
                   || (lo_x >= cnt_use);
        last_idx = IDX_W'(cnt_use - CNT_W'(1));
        hi_clip  = (hi_x >= cnt_use) ? last_idx : s_data.range_end;
        upd      = (s_data.cmd == CMD_ADD) || (s_data.cmd == CMD_SET);
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = mv_reg;
    assign m_data    = mdat_reg;

    logic [VAL_W-1:0] sv_w;
    assign sv_w = rdata;

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        hi_next      = hi_reg;
        cmd_next     = cmd_reg;
        val_next     = val_reg;
        empty_next   = empty_reg;
        rd_pend_next = 1'b0;
        sum_next     = sum_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        we           = 1'b0;
        ram_addr     = addr_reg;
        wdata        = '0;
        // fold in scan data read last cycle
        if (rd_pend_reg) begin
            sum_next = sum_reg + SUM_W'(signed'(sv_w));
            if (signed'(sv_w) > signed'(max_reg)) max_next = sv_w;
            if (signed'(sv_w) < signed'(min_reg)) min_next = sv_w;
        end
        case (state_reg)
            ST_CLR: begin
                we    = 1'b1;
                wdata = '0;
                addr_next = addr_reg + IDX_W'(1);
                if (addr_reg == IDX_W'(LEAVES - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_data.cmd;
                    val_next = s_data.value;
                    sum_next = '0;
                    max_next = INT_MIN;
                    min_next = INT_MAX;
                    if (upd) begin
                        empty_next = (cnt_use == '0);
                        if (!in_empty) begin
                            addr_next  = s_data.range_start;
                            hi_next    = hi_clip;
                            state_next = ST_URD;
                        end else if (cnt_use == '0) begin
                            state_next = ST_DONE;
                        end else begin
                            addr_next  = '0;
                            hi_next    = last_idx;
                            state_next = ST_SCAN;
                        end
                    end else begin
                        empty_next = in_empty;
                        addr_next  = s_data.range_start;
                        hi_next    = hi_clip;
                        state_next = in_empty ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_URD: begin
                state_next = ST_UWR;
            end
            ST_UWR: begin
                we    = 1'b1;
                wdata = (cmd_reg == CMD_ADD) ? rdata + val_reg : val_reg;
                if (addr_reg == hi_reg) begin
                    addr_next  = '0;
                    hi_next    = last_idx;
                    state_next = ST_SCAN;
                end else begin
                    addr_next  = addr_reg + IDX_W'(1);
                    state_next = ST_URD;
                end
            end
            ST_SCAN: begin
                rd_pend_next = 1'b1;
                if (addr_reg == hi_reg) begin
                    state_next = ST_DONE;
                end else begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                // wait for last fold and a free output register
                if (!rd_pend_reg && (!mv_reg || m_ready)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            addr_reg    <= '0;
            count_reg   <= CNT_W'(LEAVES);
            rd_pend_reg <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_pend_reg <= rd_pend_next;
            if (cfg_valid) count_reg <= cfg_data;
            if (state_reg == ST_DONE && state_next == ST_IDLE) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg    <= hi_next;
        cmd_reg   <= cmd_next;
        val_reg   <= val_next;
        empty_reg <= empty_next;
        sum_reg   <= sum_next;
        max_reg   <= max_next;
        min_reg   <= min_next;
        if (state_reg == ST_DONE && state_next == ST_IDLE) begin
            mdat_reg.range_sum   <= sum_reg;
            mdat_reg.range_max   <= max_reg;
            mdat_reg.range_min   <= min_reg;
            mdat_reg.range_empty <= empty_reg;
        end
    end

    // no item taken during clearing pass
    a_no_accept_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_ready) else $error("accept during clear");
    // write back always follows a read of the same leaf
    a_rmw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UWR) |-> $past(state_reg) == ST_URD) else $error("rmw order");
    // a result is never dropped while waiting
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |=> mv_reg && $stable(mdat_reg)) else $error("result lost");
    // scan data fold is pending only right after a scan read
    a_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> $past(state_reg) == ST_SCAN) else $error("stray fold");
endmodule

>>> dv/range_sum_min_max_tree_core_test.sv
// testbench for the range sum min max tree core: directed table plus random ops
`timescale 1ns / 100ps

module range_sum_min_max_tree_core_test;
    import rsmm_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    range_sum_min_max_tree_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the table: plain leaves are enough, node values follow from them
    logic [VAL_W-1:0] leaf_vals [LEAVES];
    logic [CNT_W-1:0] shadow_count;
    out_word_t        pending_results [$];

    int unsigned mismatches;
    int unsigned cycle_count;
    bit          calm_phase;   // no idling on either side while set

    // sum, max and min over leaves lo..hi, or the empty answer
    function automatic out_word_t range_stats(input int lo, input int hi, input bit none);
        out_word_t      r;
        logic signed [63:0] acc;
        logic signed [VAL_W-1:0] v;
        r.range_sum   = '0;
        r.range_max   = INT_MIN;
        r.range_min   = INT_MAX;
        r.range_empty = none;
        acc = 0;
        if (!none) begin
            for (int i = lo; i <= hi; i++) begin
                v = leaf_vals[i];
                acc += v;
                if (v > r.range_max) r.range_max = v;
                if (v < r.range_min) r.range_min = v;
            end
            r.range_sum = acc[SUM_W-1:0];
        end
        return r;
    endfunction

    // apply one word to the shadow table and return its expected result
    function automatic out_word_t apply_word(input in_word_t w);
        int  count;
        int  lo;
        int  hi;
        bit  none;
        count = (shadow_count > LEAVES) ? LEAVES : shadow_count;
        lo    = w.range_start;
        hi    = w.range_end;
        none  = (count == 0) || (lo > hi) || (lo >= count);
        if (!none && hi >= count) hi = count - 1;
        if (w.cmd == CMD_ADD || w.cmd == CMD_SET) begin
            if (!none) begin
                for (int i = lo; i <= hi; i++) begin
                    leaf_vals[i] = (w.cmd == CMD_ADD) ? leaf_vals[i] + w.value : w.value;
                end
            end
            return range_stats(0, count - 1, count == 0);
        end
        // query, and the unused code acts as one
        return range_stats(lo, hi, none);
    endfunction

    // predicted result of a word without touching the shadow table
    function automatic out_word_t apply_word_peek(input in_word_t w);
        logic [VAL_W-1:0] saved [LEAVES];
        out_word_t        r;
        saved = leaf_vals;
        r = apply_word(w);
        leaf_vals = saved;
        return r;
    endfunction

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog: bounded by worst case update walk times idling slack
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 8000000) begin
                $display("range_sum_min_max_tree_core_test: errors");
                $finish;
            end
        end
    end

    // result side: random stall, compare every accepted word with the oldest expectation
    initial begin
        out_word_t exp_word;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", m_data);
                end else begin
                    exp_word = pending_results.pop_front();
                    if (m_data.range_sum !== exp_word.range_sum ||
                        m_data.range_max !== exp_word.range_max ||
                        m_data.range_min !== exp_word.range_min ||
                        m_data.range_empty !== exp_word.range_empty) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("result mismatch: exp sum %0d max %0d min %0d empty %0b",
                                   exp_word.range_sum, exp_word.range_max,
                                   exp_word.range_min, exp_word.range_empty);
                            $display(", got sum %0d max %0d min %0d empty %0b",
                                     m_data.range_sum, m_data.range_max,
                                     m_data.range_min, m_data.range_empty);
                        end
                    end
                end
            end
            m_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 25);
        end
    end

    // drive one input word, idling at random beforehand; valid stays high after accept
    task automatic send_word(input in_word_t w);
        while (!calm_phase && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        pending_results.push_back(apply_word(w));
        do @(posedge aclk); while (!s_ready);
    endtask

    // write the element count once every result is back
    task automatic write_count(input logic [CNT_W-1:0] n);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        shadow_count  = n;
    endtask

    // random word: mostly short ranges, some long, some inverted or past the end
    function automatic in_word_t random_word(input int count);
        in_word_t w;
        int       lo;
        int       span;
        w.cmd = ($urandom_range(9) < 4) ? CMD_QRY :
                (($urandom_range(19) == 0) ? CMD_RSV :
                 (($urandom_range(1) == 0) ? CMD_ADD : CMD_SET));
        lo = (count > 0) ? $urandom_range(count - 1) : $urandom_range(LEAVES - 1);
        span = ($urandom_range(9) == 0) ? $urandom_range(LEAVES - 1) : $urandom_range(15);
        w.range_start = IDX_W'(lo);
        w.range_end   = (lo + span > LEAVES - 1) ? IDX_W'(LEAVES - 1) : IDX_W'(lo + span);
        if ($urandom_range(14) == 0) begin
            w.range_start = IDX_W'($urandom);
            w.range_end   = IDX_W'($urandom);
        end
        case ($urandom_range(5))
            0: w.value = INT_MIN;
            1: w.value = INT_MAX;
            2: w.value = $urandom_range(15) - 8;
            default: w.value = $urandom;
        endcase
        return w;
    endfunction

    typedef struct {
        in_word_t  word;
        bit        typed;   // expected result typed in below
        out_word_t result;
    } directed_row_t;

    localparam out_word_t EMPTY_RESULT = '{range_sum: '0, range_max: INT_MIN,
                                          range_min: INT_MAX, range_empty: 1'b1};
    localparam out_word_t ZERO_RESULT  = '{range_sum: '0, range_max: '0,
                                          range_min: '0, range_empty: 1'b0};

    directed_row_t directed_rows [] = '{
        // fresh table reads all zero
        '{'{CMD_QRY, 10'd0, 10'd1023, 32'sd0}, 1'b1, ZERO_RESULT},
        // inverted range is empty
        '{'{CMD_QRY, 10'd5, 10'd4, 32'sd0}, 1'b1, EMPTY_RESULT},
        '{'{CMD_SET, 10'd0, 10'd0, INT_MAX}, 1'b0, ZERO_RESULT},
        '{'{CMD_SET, 10'd1023, 10'd1023, INT_MIN}, 1'b0, ZERO_RESULT},
        '{'{CMD_QRY, 10'd0, 10'd0, 32'sd0}, 1'b1,
          '{range_sum: 42'sd2147483647, range_max: INT_MAX, range_min: INT_MAX,
            range_empty: 1'b0}},
        // adding one to the max element wraps it
        '{'{CMD_ADD, 10'd0, 10'd0, 32'sd1}, 1'b0, ZERO_RESULT},
        '{'{CMD_SET, 10'd0, 10'd1023, INT_MAX}, 1'b0, ZERO_RESULT},
        '{'{CMD_ADD, 10'd0, 10'd1023, INT_MAX}, 1'b0, ZERO_RESULT},
        '{'{CMD_SET, 10'd0, 10'd1023, INT_MIN}, 1'b0, ZERO_RESULT},
        '{'{CMD_QRY, 10'd100, 10'd900, 32'sd0}, 1'b0, ZERO_RESULT},
        '{'{CMD_SET, 10'd0, 10'd1023, -32'sd1}, 1'b0, ZERO_RESULT},
        '{'{CMD_ADD, 10'd3, 10'd7, 32'sh5555_5555}, 1'b0, ZERO_RESULT},
        '{'{CMD_RSV, 10'd0, 10'd9, 32'sd0}, 1'b0, ZERO_RESULT},
        '{'{CMD_QRY, 10'h2aa, 10'h355, 32'shffff_ffff}, 1'b0, ZERO_RESULT},
        '{'{CMD_SET, 10'h155, 10'h3ff, 32'sh0f0f_0f0f}, 1'b0, ZERO_RESULT}
    };

    initial begin
        in_word_t w;
        int       count;
        mismatches   = 0;
        calm_phase   = 1'b0;
        shadow_count = 11'd1024;
        for (int i = 0; i < LEAVES; i++) leaf_vals[i] = '0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, typed rows checked against the written result too
        foreach (directed_rows[r]) begin
            if (directed_rows[r].typed && apply_word_peek(directed_rows[r].word)
                    !== directed_rows[r].result) begin
                mismatches++;
                if (mismatches <= 10) $display("directed row %0d disagrees with table", r);
            end
            send_word(directed_rows[r].word);
        end

        // count extremes: nothing in use, then clipped ranges, then over range
        write_count(11'd0);
        send_word('{CMD_ADD, 10'd0, 10'd1023, 32'sd9});
        send_word('{CMD_QRY, 10'd0, 10'd0, 32'sd0});
        write_count(11'd1);
        send_word('{CMD_SET, 10'd0, 10'd1023, 32'sd7});
        send_word('{CMD_QRY, 10'd1, 10'd5, 32'sd0});
        write_count(11'd2047);
        send_word('{CMD_QRY, 10'd0, 10'd1023, 32'sd0});

        // random phases under several counts
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_count(11'd16);
                1: write_count(11'd1024);
                2: write_count(11'd3);
                3: write_count(11'd200);
                4: write_count(11'd1500);
                default: write_count(11'd64);
            endcase
            calm_phase = (p == 3);
            count = (shadow_count > LEAVES) ? LEAVES : shadow_count;
            for (int k = 0; k < 45; k++) begin
                w = random_word(count);
                send_word(w);
            end
        end
        calm_phase = 1'b0;
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("range_sum_min_max_tree_core_test: clean");
        end else begin
            $display("range_sum_min_max_tree_core_test: errors");
        end
        $finish;
    end
endmodule
